// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int LEN_W     = 6;
    // wide enough for head plus any offset or count into the store
    localparam int POS_W     = ((FILL_W > LEN_W + 1) ? FILL_W : LEN_W + 1) + 1;

    typedef logic [7:0] byte_t;

    localparam byte_t             CRC_POLY      = 8'hD5;
    localparam byte_t             CRC_TOP       = 8'h80;
    localparam byte_t             LEN_MIN       = 8'd3;
    localparam logic [LEN_W-1:0]  LEN_CAP       = 6'd62;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 6'd62;

    typedef struct packed {
        logic write_byte;
        logic drop_one;
        logic drop_frame;
        logic ofs_one;
        logic ofs_two;
        logic ofs_inc;
        logic len_load;
        logic crc_clear;
        logic crc_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_ge2;
        logic len_bad;
        logic len_short;
        logic last_pos;
        logic crc_match;
        logic out_free;
    } dp_status_t;

    // one byte through the msb-first crc-8, poly 0xd5
    function automatic byte_t crc8_step(input byte_t c);
        byte_t r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            if ((r & CRC_TOP) != 8'h00)
                r = (r << 1) ^ CRC_POLY;
            else
                r = r << 1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sfr_rx_if.sv =====
`timescale 1ns / 1ps

interface sfr_rx_if
    import sfr_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfr_frame_if.sv =====
`timescale 1ns / 1ps

interface sfr_frame_if
    import sfr_pkg::*;
;
    logic             valid;
    logic             ready;
    byte_t            frame_byte;
    logic [LEN_W-1:0] byte_index;
    logic [LEN_W-1:0] frame_length;
    logic             last;

    modport source (output valid, output frame_byte, output byte_index,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input frame_length, input last, output ready);
endinterface

// ===== rtl/core/sfr_datapath.sv =====
`timescale 1ns / 1ps

module sfr_datapath
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    input  byte_t             rx_byte,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    sfr_frame_if.source       frame
);

    byte_t              mem [BUF_DEPTH];
    byte_t              rd_data_reg;
    logic [ADDR_W-1:0]  head_reg,  head_next;
    logic [FILL_W-1:0]  fill_reg,  fill_next;
    logic [LEN_W-1:0]   ofs_reg,   ofs_next;
    logic [LEN_W-1:0]   len_reg;
    byte_t              crc_reg;
    logic [LEN_W-1:0]   max_length_reg;
    logic               out_valid_reg;
    byte_t              out_byte_reg;
    logic [LEN_W-1:0]   out_index_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic               out_last_reg;

    logic [FILL_W-1:0]  fill_eff;
    logic [POS_W-1:0]   fill_pos;
    logic [POS_W-1:0]   drop_cnt;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [LEN_W-1:0]   limit;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [POS_W-1:0] s);
        logic [POS_W-1:0] t;
        t = (s >= POS_W'(BUF_DEPTH)) ? s - POS_W'(BUF_DEPTH) : s;
        return t[ADDR_W-1:0];
    endfunction

    // a full store restarts empty before the new byte goes in
    assign fill_eff = (fill_reg == FILL_W'(BUF_DEPTH)) ? '0 : fill_reg;
    assign fill_pos = POS_W'(fill_reg);
    assign drop_cnt = cmd.drop_frame ? POS_W'(len_reg) + POS_W'(2) : POS_W'(1);
    assign wr_addr  = wrap_addr(POS_W'(head_reg) + POS_W'(fill_eff));
    // read runs one step ahead so the registered data matches ofs_reg
    assign rd_addr  = wrap_addr(POS_W'(head_reg) + POS_W'(ofs_next));
    assign limit    = (max_length_reg > LEN_CAP) ? LEN_CAP : max_length_reg;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.write_byte)
        begin
            fill_next = fill_eff + 1'b1;
        end
        else if (cmd.drop_one || cmd.drop_frame)
        begin
            if (drop_cnt >= fill_pos)
            begin
                fill_next = '0;
            end
            else
            begin
                head_next = wrap_addr(POS_W'(head_reg) + drop_cnt);
                fill_next = FILL_W'(fill_pos - drop_cnt);
            end
        end
    end

    always_comb
    begin
        priority if (cmd.ofs_one)
            ofs_next = LEN_W'(1);
        else if (cmd.ofs_two)
            ofs_next = LEN_W'(2);
        else if (cmd.ofs_inc)
            ofs_next = ofs_reg + 1'b1;
        else
            ofs_next = ofs_reg;
    end

    assign status.fill_ge2  = (fill_reg >= FILL_W'(2));
    assign status.len_bad   = (rd_data_reg < LEN_MIN) || (rd_data_reg > byte_t'(limit));
    assign status.len_short = fill_pos < (POS_W'(rd_data_reg[LEN_W-1:0]) + POS_W'(2));
    assign status.last_pos  = (ofs_reg == len_reg);
    assign status.crc_match = (crc_reg == rd_data_reg);
    assign status.out_free  = !out_valid_reg || frame.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
            mem[wr_addr] <= rx_byte;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            fill_reg       <= '0;
            ofs_reg        <= LEN_W'(1);
            max_length_reg <= MAX_LEN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            ofs_reg  <= ofs_next;
            if (cfg_wr_en)
                max_length_reg <= cfg_wr_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (frame.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.len_load)
            len_reg <= rd_data_reg[LEN_W-1:0];
        if (cmd.crc_clear)
            crc_reg <= '0;
        else if (cmd.crc_step)
            crc_reg <= crc8_step(crc_reg ^ rd_data_reg);
        if (cmd.out_load)
        begin
            out_byte_reg  <= rd_data_reg;
            out_index_reg <= ofs_reg - LEN_W'(2);
            out_len_reg   <= len_reg;
            out_last_reg  <= status.last_pos;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.frame_byte   = out_byte_reg;
    assign frame.byte_index   = out_index_reg;
    assign frame.frame_length = out_len_reg;
    assign frame.last         = out_last_reg;

endmodule

// ===== rtl/core/sfr_ctrl.sv =====
`timescale 1ns / 1ps

module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_LEN,
        S_CHECK_LEN,
        S_CRC,
        S_CMP,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.write_byte = 1'b1;
                    state_next     = S_READ_LEN;
                end
            end
            S_READ_LEN:
            begin
                // length byte is read this cycle
                state_next = status.fill_ge2 ? S_CHECK_LEN : S_IDLE;
            end
            S_CHECK_LEN:
            begin
                if (status.len_bad)
                begin
                    cmd.drop_one = 1'b1;
                    cmd.ofs_one  = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (status.len_short)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.len_load  = 1'b1;
                    cmd.crc_clear = 1'b1;
                    cmd.ofs_two   = 1'b1;
                    state_next    = S_CRC;
                end
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
                cmd.ofs_inc  = 1'b1;
                if (status.last_pos)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (status.crc_match)
                begin
                    cmd.ofs_two = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.drop_one = 1'b1;
                    cmd.ofs_one  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.last_pos)
                    begin
                        // last word is loaded into the output register as the frame leaves the store
                        cmd.drop_frame = 1'b1;
                        cmd.ofs_one    = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.ofs_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/serial_frame_receiver_crc8.sv =====
`timescale 1ns / 1ps
// Serial frame receiver with CRC-8 (poly 0xD5) check.
// rx: one received serial byte per word, valid/ready. Bytes collect in a
// 64-entry circular store; byte 1 of the store is the frame length.
// frame: type and payload bytes of each frame whose CRC matches, one word
// each, with byte_index and frame_length; last marks the final word.
// cfg_wr_en / cfg_wr_data write max_length; write it only while idle.
// After each byte the block checks the store before the next byte is taken.
// Once a frame of length L is held, the CRC walk reads its L - 1 type and
// payload bytes, one byte per cycle through the single store read port; a
// good frame then emits those L - 1 words, one word per cycle from the same
// port while the output is not stalled.
// Reset empties the store and sets max_length to 62; the store contents
// themselves are not cleared and no clearing pass is needed.
// When frame.ready is low, emission holds on a one-word output register;
// the final word of a frame may still wait there while the next rx byte
// is accepted.

module serial_frame_receiver_crc8
    import sfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [LEN_W-1:0]  cfg_wr_data,
    sfr_rx_if.sink            rx,
    sfr_frame_if.source       frame
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic        in_ready;

    assign rx.ready = in_ready;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (rx.rx_byte),
        .cmd         (cmd),
        .status      (status),
        .frame       (frame)
    );

    // never overwrite a word that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output word overwritten");

    // after a byte is taken the block is busy checking it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |=> !rx.ready)
        else $error("byte accepted while previous still in work");

    // store updates never collide
    a_one_store_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write_byte, cmd.drop_one, cmd.drop_frame}))
        else $error("conflicting store updates");

    // a frame leaves the store only together with its last word
    a_frame_drop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_frame |-> (cmd.out_load && status.last_pos))
        else $error("frame dropped without its last word");

endmodule
